// ----- sv/gsc_pkg.sv -----
// Shared types, constants and helpers for the grid square clearance block.
// Depends on nothing; every other file of the block imports it.
package gsc_pkg;

   // Store geometry: one memory row holds one map row.
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);

   // Field widths fixed by the item format.
   localparam int COORD_W = 6;
   localparam int DIM_W   = 7;

   localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);
   localparam logic [ROW_AW-1:0] LAST_ROW      = ROW_AW'(MAX_HEIGHT - 1);

   // Item kinds.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Register map: word index taken from paddr[2].
   localparam int  CSR_AW         = 3;
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   // Request to the row memory.
   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ROW_AW-1:0]    addr;
      logic [MAX_WIDTH-1:0] wdata;
   } ram_req_type;

   // Zero acts as one, anything above the store size acts as the store size.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] d;
      begin
         d = v;
         if (d == '0) d = DIM_W'(1);
         if (d > maxv) d = maxv;
         return d;
      end
   endfunction

endpackage

// ----- sv/gsc_row_ram.sv -----
// Row-wide single-port memory holding the passable bitmap, one map row per word.
// Depends on gsc_pkg for the geometry and the request struct.
module gsc_row_ram
   import gsc_pkg::*;
(
   input  logic                 clock,
   input  ram_req_type          req,
   output logic [MAX_WIDTH-1:0] rd_data
);

   logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gsc_csr.sv -----
// APB-style register file holding the configured map width and height.
// Depends on gsc_pkg for the register map and the clamping helper.
module gsc_csr
   import gsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output logic [DIM_W-1:0]  map_width,
   output logic [DIM_W-1:0]  map_height
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register writes, clamped to the legal range on the way in.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_MAP_WIDTH: begin
               width_in = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_WIDTH_DIM);
            end
            REG_MAP_HEIGHT: begin
               height_in = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_HEIGHT_DIM);
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(DIM_W'(64), MAX_WIDTH_DIM);
         height_ff <= clamp_dim(DIM_W'(64), MAX_HEIGHT_DIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read data.
   always_comb begin
      unique case (csr_paddr[2])
         REG_MAP_WIDTH:  csr_prdata = {{(32-DIM_W){1'b0}}, width_ff};
         REG_MAP_HEIGHT: csr_prdata = {{(32-DIM_W){1'b0}}, height_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign map_width  = width_ff;
   assign map_height = height_ff;

endmodule

// ----- sv/gsc_engine.sv -----
// Sequencer for the clearance block: clears the store after reset, does the
// read-modify-write of a cell write and the row-by-row square growth of a query.
// Depends on gsc_pkg; drives the row memory through a ram_req_type request.
module gsc_engine
   import gsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [DIM_W-1:0]     map_width,
   input  logic [DIM_W-1:0]     map_height,
   // Input item.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [COORD_W-1:0]   req_column,
   input  logic                 req_passable,
   // Result item.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DIM_W-1:0]     rsp_clearance,
   output logic                 rsp_out_of_map,
   // Row memory.
   output ram_req_type          ram_req,
   input  logic [MAX_WIDTH-1:0] ram_rd_data
);

   state_type state_ff, state_in;

   logic [ROW_AW-1:0]    clr_ff, clr_in;
   logic                 mode_ff, mode_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic [COORD_W-1:0]   col_ff, col_in;
   logic                 pass_ff, pass_in;
   logic                 oom_ff, oom_in;
   logic [DIM_W-1:0]     k_ff, k_in;
   logic [ROW_AW-1:0]    rdrow_ff, rdrow_in;
   logic [MAX_WIDTH-1:0] mask_ff, mask_in;
   logic [MAX_WIDTH-1:0] acc_ff, acc_in;
   logic [DIM_W-1:0]     res_k_ff, res_k_in;
   logic                 res_oom_ff, res_oom_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]     rsp_k_ff, rsp_k_in;
   logic                 rsp_oom_ff, rsp_oom_in;

   logic                 accept;
   logic                 out_free;
   logic                 in_store;
   logic                 square_ok;
   logic                 can_grow;
   logic [DIM_W-1:0]     k_next;
   logic [MAX_WIDTH-1:0] acc_rd;
   logic [MAX_WIDTH-1:0] col_bit;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign in_store = DIM_W'(row_ff) < MAX_HEIGHT_DIM && DIM_W'(col_ff) < MAX_WIDTH_DIM;
   assign col_bit  = MAX_WIDTH'(1) << col_ff;

   // Square test for the row just read: rows so far must cover the mask.
   assign acc_rd    = acc_ff & ram_rd_data;
   assign square_ok = (acc_rd & mask_ff) == mask_ff;
   assign k_next    = k_ff + DIM_W'(1);
   assign can_grow  = (DIM_W'(row_ff) + k_next) < map_height
                   && (DIM_W'(col_ff) + k_next) < map_width;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ROW) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            priority if (mode_ff == MODE_WRITE) state_in = ST_IDLE;
            else if (oom_ff)                    state_in = ST_DONE;
            else if (!(square_ok && can_grow))  state_in = ST_DONE;
            else                                state_in = ST_EXEC;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory requests.
   always_comb begin
      clr_in      = clr_ff;
      mode_in     = mode_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pass_in     = pass_ff;
      oom_in      = oom_ff;
      k_in        = k_ff;
      rdrow_in    = rdrow_ff;
      mask_in     = mask_ff;
      acc_in      = acc_ff;
      res_k_in    = res_k_ff;
      res_oom_in  = res_oom_ff;
      ram_req     = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // One row of zeros a cycle.
            ram_req.we   = 1'b1;
            ram_req.addr = clr_ff;
            clr_in       = clr_ff + ROW_AW'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            // Capture the item and fetch its own row.
            mode_in      = req_mode;
            row_in       = req_row;
            col_in       = req_column;
            pass_in      = req_passable;
            oom_in       = DIM_W'(req_row) >= map_height || DIM_W'(req_column) >= map_width;
            k_in         = '0;
            rdrow_in     = ROW_AW'(req_row);
            mask_in      = MAX_WIDTH'(1) << req_column;
            acc_in       = '1;
            ram_req.re   = accept;
            ram_req.addr = ROW_AW'(req_row);
         end
         ST_EXEC: begin
            priority if (mode_ff == MODE_WRITE) begin
               // Write back the row with the one cell replaced.
               ram_req.we    = in_store;
               ram_req.addr  = ROW_AW'(row_ff);
               ram_req.wdata = pass_ff ? (ram_rd_data | col_bit)
                                       : (ram_rd_data & ~col_bit);
            end else if (oom_ff) begin
               res_k_in   = '0;
               res_oom_in = 1'b1;
            end else begin
               res_oom_in = 1'b0;
               acc_in     = acc_rd;
               if (square_ok) begin
                  k_in     = k_next;
                  res_k_in = k_next;
                  if (can_grow) begin
                     // Widen by one column and fetch the next row.
                     rdrow_in     = rdrow_ff + ROW_AW'(1);
                     mask_in      = mask_ff | (mask_ff << 1);
                     ram_req.re   = 1'b1;
                     ram_req.addr = rdrow_ff + ROW_AW'(1);
                  end
               end else begin
                  res_k_in = k_ff;
               end
            end
         end
         ST_DONE: begin
            res_k_in = res_k_ff;
         end
         default: begin
            ram_req = '0;
         end
      endcase
   end

   // Output register: loads when the result is ready and the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_k_in     = rsp_k_ff;
      rsp_oom_in   = rsp_oom_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_k_in     = res_k_ff;
         rsp_oom_in   = res_oom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      pass_ff    <= pass_in;
      oom_ff     <= oom_in;
      k_ff       <= k_in;
      rdrow_ff   <= rdrow_in;
      mask_ff    <= mask_in;
      acc_ff     <= acc_in;
      res_k_ff   <= res_k_in;
      res_oom_ff <= res_oom_in;
      rsp_k_ff   <= rsp_k_in;
      rsp_oom_ff <= rsp_oom_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clearance  = rsp_k_ff;
   assign rsp_out_of_map = rsp_oom_ff;

endmodule

// ----- sv/grid_square_clearance.sv -----
// Grid square clearance: passable bitmap with clearance queries.
// A cell write reads its row and writes it back changed; a query reads one row of the row
// memory per row of the square, from its own row downwards, until the square fails or the
// map edge stops it. Throughput: one transaction per write or query time; the row memory
// port sets it. Reset: synchronous, active high; afterwards a clearing pass writes zeros
// to every row, marking every cell blocked, during which no input transaction is taken. Registers reset to 64.
module grid_square_clearance
   import gsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Input stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // row [5:0], column [11:6], passable [12], zero
   input  logic              req_tuser,   // mode (0 write, 1 query)
   // Result stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // clearance [6:0], zero [7]
   output logic              rsp_tuser,   // out_of_map
   // Configuration port.
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [DIM_W-1:0]     map_width;
   logic [DIM_W-1:0]     map_height;
   logic [DIM_W-1:0]     clearance;
   ram_req_type          ram_req;
   logic [MAX_WIDTH-1:0] ram_rd_data;

   // Configuration registers.
   gsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .map_width   (map_width),
      .map_height  (map_height)
   );

   // Sequencer.
   gsc_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .map_width      (map_width),
      .map_height     (map_height),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser),
      .req_row        (req_tdata[5:0]),
      .req_column     (req_tdata[11:6]),
      .req_passable   (req_tdata[12]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_clearance  (clearance),
      .rsp_out_of_map (rsp_tuser),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data)
   );

   // Bitmap store.
   gsc_row_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {1'b0, clearance};

`ifndef SYNTHESIS
   // A query outside the map never reports a clearance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("out-of-map result carries a nonzero clearance");

   // A clearance never exceeds the configured map width or height.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> clearance <= map_width && clearance <= map_height)
      else $error("clearance larger than the map");

   // Checks that no input transaction is taken at the start of the clearing pass after reset.
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during the clearing pass");
`endif

endmodule
